@@ rtl/core/lfs_pkg.sv @@
// Shared types and codes for the LED strip frame sender.
// No dependencies; every other file in rtl/core uses it.
`default_nettype none

package lfs_pkg;

   localparam int SLOT_W = 8;

   localparam logic [1:0] FUNC_SET     = 2'd0;
   localparam logic [1:0] FUNC_SET_ALL = 2'd1;
   localparam logic [1:0] FUNC_FLUSH   = 2'd2;
   localparam logic [1:0] FUNC_TICK    = 2'd3;

   localparam logic [1:0] PHASE_IDLE  = 2'd0;
   localparam logic [1:0] PHASE_BUSY  = 2'd1;
   localparam logic [1:0] PHASE_DIRTY = 2'd2;

   localparam logic [7:0] BYTE_START = 8'h00;
   localparam logic [7:0] BYTE_MARK  = 8'hFF;

   typedef struct packed {
      logic [1:0] func;
      logic [7:0] led_index;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } req_type;

   typedef struct packed {
      logic       send_valid;
      logic [7:0] out_byte;
      logic [1:0] link_state;
      logic       frame_done;
   } rsp_type;

   // Classified command as it sits in the queue
   typedef struct packed {
      logic [1:0]        func;
      logic              in_range;
      logic [SLOT_W-1:0] slot;
      logic [23:0]       colour;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } queue_head_type;

endpackage

`default_nettype wire

@@ rtl/core/lfs_front.sv @@
// Front end: accepts request items, decodes slot and range, queues them.
// Depends on lfs_pkg.
`default_nettype none

module lfs_front #(
   parameter int LED_TOTAL = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire lfs_pkg::req_type       req_data,
   output lfs_pkg::queue_head_type     head,
   input  wire logic                   pop
);

   localparam logic [7:0] LED_LAST = 8'(LED_TOTAL - 1);

   lfs_pkg::cmd_type fifo_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   lfs_pkg::cmd_type cmd;
   logic       push;

   // Reverse the index so the last LED goes out first
   always_comb begin
      cmd.func     = req_data.func;
      cmd.in_range = req_data.led_index <= LED_LAST;
      cmd.slot     = LED_LAST - req_data.led_index;
      cmd.colour   = {req_data.red, req_data.green, req_data.blue};
   end

   assign req_ready = count_ff != 2'd2;
   assign push      = req_valid && req_ready;

   assign head.valid = count_ff != 2'd0;
   assign head.cmd   = fifo_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ptr_ff] <= cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != 2'd0)
      else $error("pop from empty queue");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff == 2'd2 |=> count_ff != 2'd0)
      else $error("queue count jumped from full to empty");

   a_full_no_push: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd2 && !pop) |=> count_ff == 2'd2)
      else $error("full queue lost an entry");

endmodule

`default_nettype wire

@@ rtl/core/lfs_back.sv @@
// Back end: colour store, send snapshot, frame sequencer and result register.
// Depends on lfs_pkg; fed by lfs_front.
`default_nettype none

module lfs_back #(
   parameter int LED_TOTAL = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire lfs_pkg::queue_head_type head,
   output logic                        pop,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output lfs_pkg::rsp_type            rsp_data
);

   localparam int IDX_W       = (LED_TOTAL > 1) ? $clog2(LED_TOTAL) : 1;
   localparam int CNT_W       = $clog2(LED_TOTAL + 1);
   localparam int FRAME_BYTES = 4 * LED_TOTAL + 8;
   localparam int POS_W       = $clog2(FRAME_BYTES + 1);
   localparam int LED_W       = POS_W - 2;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_FILL = 2'd1;
   localparam logic [1:0] S_COPY = 2'd2;
   localparam logic [1:0] S_BYTE = 2'd3;

   logic [1:0]       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [1:0]       phase_ff, phase_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [23:0]      colour_ff, colour_in;
   logic             done_ff, done_in;
   logic [1:0]       sub_ff, sub_in;
   logic             rsp_valid_ff, rsp_valid_in;
   lfs_pkg::rsp_type rsp_ff, rsp_in;

   logic [23:0]          store_mem [LED_TOTAL];
   logic [LED_TOTAL-1:0] store_vld_ff, store_vld_in;
   logic                 store_we;
   logic [IDX_W-1:0]     store_waddr;
   logic [23:0]          store_wdata;
   logic [23:0]          store_rd_ff;
   logic                 store_vrd_ff;
   logic [IDX_W-1:0]     store_raddr;

   logic [23:0]      snap_mem [LED_TOTAL];
   logic [23:0]      snap_rd_ff;
   logic [IDX_W-1:0] snap_raddr;
   logic             cp_we_ff, cp_we_in;
   logic [IDX_W-1:0] cp_addr_ff, cp_addr_in;

   logic [POS_W-1:0] rel_pos;
   logic [LED_W-1:0] led_num;
   logic             out_free;
   logic [7:0]       colour_byte;

   assign rel_pos     = pos_ff - POS_W'(4);
   assign led_num     = rel_pos[POS_W-1:2];
   assign snap_raddr  = led_num[IDX_W-1:0];
   assign store_raddr = cnt_ff[IDX_W-1:0];
   assign out_free    = !rsp_valid_ff || rsp_ready;

   always_comb begin
      case (sub_ff)
         2'd1:    colour_byte = snap_rd_ff[7:0];
         2'd2:    colour_byte = snap_rd_ff[15:8];
         2'd3:    colour_byte = snap_rd_ff[23:16];
         default: colour_byte = lfs_pkg::BYTE_MARK;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      phase_in     = phase_ff;
      pos_in       = pos_ff;
      colour_in    = colour_ff;
      done_in      = done_ff;
      sub_in       = sub_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      store_vld_in = store_vld_ff;
      store_we     = 1'b0;
      store_waddr  = head.cmd.slot[IDX_W-1:0];
      store_wdata  = head.cmd.colour;
      cp_we_in     = 1'b0;
      cp_addr_in   = store_raddr;
      pop          = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (head.valid && out_free) begin
               pop          = 1'b1;
               colour_in    = head.cmd.colour;
               rsp_valid_in = 1'b1;
               rsp_in       = '{send_valid: 1'b0, out_byte: lfs_pkg::BYTE_START,
                                link_state: phase_ff, frame_done: 1'b0};
               case (head.cmd.func)
                  lfs_pkg::FUNC_SET: begin
                     if (head.cmd.in_range) begin
                        store_we                 = 1'b1;
                        store_vld_in[store_waddr] = 1'b1;
                     end
                  end
                  lfs_pkg::FUNC_SET_ALL: begin
                     rsp_valid_in = 1'b0;
                     cnt_in       = '0;
                     state_in     = S_FILL;
                  end
                  lfs_pkg::FUNC_FLUSH: begin
                     if (phase_ff == lfs_pkg::PHASE_IDLE) begin
                        rsp_valid_in = 1'b0;
                        cnt_in       = '0;
                        done_in      = 1'b0;
                        state_in     = S_COPY;
                     end else begin
                        phase_in           = lfs_pkg::PHASE_DIRTY;
                        rsp_in.link_state  = lfs_pkg::PHASE_DIRTY;
                     end
                  end
                  default: begin
                     if (phase_ff == lfs_pkg::PHASE_IDLE) begin
                        // tick while idle: nothing to send
                     end else if (pos_ff >= POS_W'(FRAME_BYTES)) begin
                        if (phase_ff == lfs_pkg::PHASE_DIRTY) begin
                           rsp_valid_in = 1'b0;
                           cnt_in       = '0;
                           done_in      = 1'b1;
                           state_in     = S_COPY;
                        end else begin
                           phase_in          = lfs_pkg::PHASE_IDLE;
                           pos_in            = '0;
                           rsp_in.link_state = lfs_pkg::PHASE_IDLE;
                           rsp_in.frame_done = 1'b1;
                        end
                     end else begin
                        pos_in            = pos_ff + POS_W'(1);
                        rsp_in.send_valid = 1'b1;
                        if (pos_ff < POS_W'(4)) begin
                           rsp_in.out_byte = lfs_pkg::BYTE_START;
                        end else if (rel_pos[1:0] == 2'd0 ||
                                     led_num >= LED_W'(LED_TOTAL)) begin
                           rsp_in.out_byte = lfs_pkg::BYTE_MARK;
                        end else begin
                           // wait in S_BYTE for the registered snapshot read
                           rsp_valid_in = 1'b0;
                           sub_in       = rel_pos[1:0];
                           state_in     = S_BYTE;
                        end
                     end
                  end
               endcase
            end
         end
         S_FILL: begin
            store_we                  = 1'b1;
            store_waddr               = store_raddr;
            store_wdata               = colour_ff;
            store_vld_in[store_raddr] = 1'b1;
            if (cnt_ff == CNT_W'(LED_TOTAL - 1)) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{send_valid: 1'b0, out_byte: lfs_pkg::BYTE_START,
                                link_state: phase_ff, frame_done: 1'b0};
               state_in     = S_IDLE;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         S_COPY: begin
            if (cnt_ff != CNT_W'(LED_TOTAL)) begin
               cp_we_in = 1'b1;
               cnt_in   = cnt_ff + CNT_W'(1);
            end else begin
               phase_in     = lfs_pkg::PHASE_BUSY;
               pos_in       = POS_W'(1);
               rsp_valid_in = 1'b1;
               rsp_in       = '{send_valid: 1'b1, out_byte: lfs_pkg::BYTE_START,
                                link_state: lfs_pkg::PHASE_BUSY, frame_done: done_ff};
               state_in     = S_IDLE;
            end
         end
         default: begin
            rsp_valid_in = 1'b1;
            rsp_in       = '{send_valid: 1'b1, out_byte: colour_byte,
                             link_state: phase_ff, frame_done: 1'b0};
            state_in     = S_IDLE;
         end
      endcase
   end

   // Store and snapshot memories, registered reads
   always_ff @(posedge clock) begin
      if (store_we) begin
         store_mem[store_waddr] <= store_wdata;
      end
      store_rd_ff  <= store_mem[store_raddr];
      store_vrd_ff <= store_vld_ff[store_raddr];
   end

   always_ff @(posedge clock) begin
      if (cp_we_ff) begin
         snap_mem[cp_addr_ff] <= store_vrd_ff ? store_rd_ff : 24'd0;
      end
      snap_rd_ff <= snap_mem[snap_raddr];
   end

   always_ff @(posedge clock) begin
      cnt_ff     <= cnt_in;
      colour_ff  <= colour_in;
      done_ff    <= done_in;
      sub_ff     <= sub_in;
      rsp_ff     <= rsp_in;
      cp_addr_ff <= cp_addr_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= lfs_pkg::PHASE_IDLE;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         store_vld_ff <= '0;
         cp_we_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
         store_vld_ff <= store_vld_in;
         cp_we_ff     <= cp_we_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      pop |-> (state_ff == S_IDLE && out_free))
      else $error("item taken while sequencer busy or result blocked");

   a_idle_pos: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == lfs_pkg::PHASE_IDLE) |-> (pos_ff == '0))
      else $error("byte position not cleared while idle");

   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= POS_W'(FRAME_BYTES))
      else $error("byte position past end of frame");

   a_send_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.send_valid) |-> (rsp_ff.link_state != lfs_pkg::PHASE_IDLE))
      else $error("byte sent while link idle");

   a_busy_no_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !rsp_valid_ff)
      else $error("result register occupied during multi-cycle command");

endmodule

`default_nettype wire

@@ rtl/core/led_strip_frame_sender_unit.sv @@
// Top level of the LED strip frame sender: command queue plus frame sequencer.
// Depends on lfs_pkg, lfs_front and lfs_back.
//
//   channel   dir   handshake               payload
//   req       in    req_valid / req_ready   req_data (lfs_pkg::req_type)
//   rsp       out   rsp_valid / rsp_ready   rsp_data (lfs_pkg::rsp_type)
//
// Set, flush-while-sending and start/marker/end-byte ticks take 1 cycle each.
// A tick on a colour byte passes through S_BYTE for the registered snapshot memory read.
// Set-all is the accept, then S_FILL with one store write per cycle;
// a frame start (flush while idle, or a dirty frame end) is the accept,
// then S_COPY, which copies the store into the snapshot.
// Reset is synchronous and clears the store through per-entry valid bits at once.
// A two-entry queue takes items until full while the result waits on rsp_ready.
`default_nettype none

module led_strip_frame_sender_unit #(
   parameter int LED_TOTAL = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire lfs_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output lfs_pkg::rsp_type      rsp_data
);

   lfs_pkg::queue_head_type head;
   logic                    pop;

   lfs_front #(.LED_TOTAL(LED_TOTAL)) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .head      (head),
      .pop       (pop)
   );

   lfs_back #(.LED_TOTAL(LED_TOTAL)) u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire
